// File: src/vwbp_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the variable-width bit packer.
// No dependencies; used by every module of the block.
package vwbp_pkg;

  localparam int unsigned ByteBits      = 8;
  localparam int unsigned CountBits     = 4;
  localparam int unsigned FillBits      = 3;
  localparam int unsigned DefFifoDepth  = 4;

  typedef struct packed {
    logic [ByteBits-1:0] data;
    logic                fin;
  } res_t;

  typedef struct packed {
    logic valid0;
    logic valid1;
    res_t res0;
    res_t res1;
  } pack_out_t;

endpackage

// File: src/vwbp_packer.sv
`timescale 1ns / 1ps
// Packing core: holds the bit accumulator and fill count and merges one item.
// Depends on vwbp_pkg; produces up to two result items per accepted item.
module vwbp_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [vwbp_pkg::ByteBits-1:0]  data_value_i,
  input  logic [vwbp_pkg::CountBits-1:0] bit_count_i,
  input  logic                           end_of_stream_i,
  output vwbp_pkg::pack_out_t            pack_o
);

  localparam int unsigned BB = vwbp_pkg::ByteBits;
  localparam int unsigned FB = vwbp_pkg::FillBits;
  localparam int unsigned CB = vwbp_pkg::CountBits;

  logic [BB-1:0]   acc_q, acc_d;
  logic [FB-1:0]   fill_q, fill_d;

  logic [CB-1:0]   width;
  logic [BB-1:0]   masked;
  logic [CB-1:0]   total;
  logic [2*BB-1:0] combined;
  logic [CB:0]     shamt;
  logic            emit0;
  logic [BB-1:0]   acc_mid;
  logic [FB-1:0]   fill_mid;

  always_comb begin
    width  = (bit_count_i > CB'(BB)) ? CB'(BB) : bit_count_i;
    masked = data_value_i & BB'((9'd1 << width) - 9'd1);
    total  = CB'(fill_q) + width;
    shamt  = (CB+1)'(2*BB) - (CB+1)'(total);
    combined = {acc_q, {BB{1'b0}}} | ((2*BB)'(masked) << shamt);
    emit0    = 1'b0;
    acc_mid  = acc_q;
    fill_mid = fill_q;
    if (width != '0) begin
      if (total >= CB'(BB)) begin
        emit0    = 1'b1;
        acc_mid  = combined[BB-1:0];
        fill_mid = FB'(total - CB'(BB));
      end else begin
        acc_mid  = combined[2*BB-1:BB];
        fill_mid = FB'(total);
      end
    end
  end

  always_comb begin
    pack_o        = '0;
    pack_o.res0.data = combined[2*BB-1:BB];
    pack_o.res1.data = acc_mid;
    pack_o.res1.fin  = 1'b1;
    pack_o.valid0 = emit0;
    acc_d  = acc_mid;
    fill_d = fill_mid;
    if (end_of_stream_i) begin
      if (fill_mid != '0) begin
        if (emit0) begin
          pack_o.valid1 = 1'b1;
        end else begin
          pack_o.valid0    = 1'b1;
          pack_o.res0.data = acc_mid;
          pack_o.res0.fin  = 1'b1;
        end
      end else if (emit0) begin
        pack_o.res0.fin = 1'b1;
      end
      acc_d  = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      fill_q <= '0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      fill_q <= fill_d;
    end
  end

endmodule

// File: src/vwbp_result_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two items per cycle and delivers one per cycle while the output is not stalled.
// Depends on vwbp_pkg for the result item type.
module vwbp_result_fifo #(
  parameter int unsigned Depth = vwbp_pkg::DefFifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push0_i,
  input  logic                push1_i,
  input  vwbp_pkg::res_t      wdata0_i,
  input  vwbp_pkg::res_t      wdata1_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vwbp_pkg::res_t      rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vwbp_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d, tail1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) r = '0;
    else r = p + PtrW'(1);
    return r;
  endfunction

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign rdata_o     = mem_q[head_q];
  assign room2_o     = (cnt_q <= CntW'(Depth - 2));
  assign tail1       = ptr_inc(tail_q);

  always_comb begin
    head_d = pop ? ptr_inc(head_q) : head_q;
    if (push1_i) tail_d = ptr_inc(tail1);
    else if (push0_i) tail_d = tail1;
    else tail_d = tail_q;
    cnt_d = cnt_q + CntW'(push0_i) + CntW'(push1_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push0_i) mem_q[tail_q] <= wdata0_i;
    if (push1_i) mem_q[tail1]  <= wdata1_i;
  end

endmodule

// File: src/variable_width_bit_packer.sv
`timescale 1ns / 1ps
// Variable-width bit packer, MSB first; top level joining the packer and result queue.
// With an empty result queue, an item's first byte is visible on the output in the cycle
// after it is accepted.
// Throughput: one item per cycle while the output drains one byte per cycle; an end-of-stream
// item that flushes two bytes leaves one extra byte queued, and input stalls while more than
// FifoDepth-2 bytes wait. Reset: asynchronous active-low reset clears accumulator, count and queue.
module variable_width_bit_packer #(
  parameter int unsigned FifoDepth = vwbp_pkg::DefFifoDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vwbp_pkg::ByteBits-1:0]  data_value_i,
  input  logic [vwbp_pkg::CountBits-1:0] bit_count_i,
  input  logic                           end_of_stream_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [vwbp_pkg::ByteBits-1:0]  packed_byte_o,
  output logic                           final_byte_o
);

  vwbp_pkg::pack_out_t pack;
  vwbp_pkg::res_t      head;
  logic                room2;
  logic                accept;

  assign in_stall_o = !room2;
  assign accept     = in_valid_i && room2;

  vwbp_packer u_packer (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_value_i    (data_value_i),
    .bit_count_i     (bit_count_i),
    .end_of_stream_i (end_of_stream_i),
    .pack_o          (pack)
  );

  vwbp_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push0_i     (accept && pack.valid0),
    .push1_i     (accept && pack.valid1),
    .wdata0_i    (pack.res0),
    .wdata1_i    (pack.res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rdata_o     (head)
  );

  assign packed_byte_o = head.data;
  assign final_byte_o  = head.fin;

endmodule
